// ----- hw/rtl/bounded_edit_distance_check_defines.svh -----
// Assertion macros for the bounded edit distance check.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef BOUNDED_EDIT_DISTANCE_CHECK_DEFINES_SVH
`define BOUNDED_EDIT_DISTANCE_CHECK_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at each rising clock edge
`define BEDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bedc assertion failed");
// Next-cycle implication
`define BEDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bedc assertion failed");
`else
`define BEDC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BEDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/bedc_pkg.sv -----
// Shared types, codes and helpers for the bounded edit distance check.
// No dependencies.
`timescale 1ns / 1ps
package bedc_pkg;

  localparam int unsigned MaxLenDef = 256;

  // Request modes
  localparam logic [1:0] MODE_SRC = 2'd0;
  localparam logic [1:0] MODE_TGT = 2'd1;
  localparam logic [1:0] MODE_CMP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PRE,
    ST_CELL,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic idle;
    logic init_wr;
    logic pre;
    logic calc;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic quick;
    logic init_last;
    logic cell_last;
    logic row_last;
  } sts_t;

  // Fold ASCII upper case to lower case
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/bedc_in_if.sv -----
// Request channel interface: mode, symbol and threshold with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
interface bedc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] symbol;
  logic [8:0] threshold;

  modport source (output valid, mode, symbol, threshold, input ready);
  modport sink (input valid, mode, symbol, threshold, output ready);
endinterface

// ----- hw/rtl/bedc_out_if.sv -----
// Result channel interface: within_res and too_long with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
interface bedc_out_if;
  logic valid;
  logic ready;
  logic within_res;
  logic too_long;

  modport source (output valid, within_res, too_long, input ready);
  modport sink (input valid, within_res, too_long, output ready);
endinterface

// ----- hw/rtl/bedc_ctrl.sv -----
// Controller state machine for the bounded edit distance check.
// Depends on bedc_pkg.
`timescale 1ns / 1ps
module bedc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bedc_pkg::sts_t sts_i,
  output bedc_pkg::cmd_t cmd_o
);
  import bedc_pkg::*;

  state_e state_q, state_d;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_INIT;
      end
      ST_INIT: begin
        if (sts_i.quick) state_d = ST_DONE;
        else if (sts_i.init_last) state_d = ST_PRE;
      end
      ST_PRE: state_d = ST_CELL;
      ST_CELL: begin
        if (sts_i.cell_last && sts_i.row_last) state_d = ST_DONE;
        else if (sts_i.cell_last) state_d = ST_PRE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.idle = 1'b1;
      ST_INIT: cmd_o.init_wr = !sts_i.quick;
      ST_PRE:  cmd_o.pre = 1'b1;
      ST_CELL: cmd_o.calc = 1'b1;
      ST_DONE: cmd_o.finish = 1'b1;
      default: cmd_o = '0;
    endcase
  end
endmodule

// ----- hw/rtl/bedc_dp.sv -----
// Datapath: string stores, DP row memory, cell update and result register.
// Depends on bedc_pkg.
`timescale 1ns / 1ps
module bedc_dp #(
  parameter int unsigned MAX_LEN = bedc_pkg::MaxLenDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           app_src_i,
  input  logic           app_tgt_i,
  input  logic           start_i,
  input  logic [7:0]     symbol_i,
  input  logic [8:0]     threshold_i,
  input  bedc_pkg::cmd_t cmd_i,
  output bedc_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           within_res_o,
  output logic           too_long_o
);
  import bedc_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned DW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] LenMax = CW'(MAX_LEN);

  logic [7:0]    src_mem [MAX_LEN];
  logic [7:0]    tgt_mem [MAX_LEN];
  logic [CW-1:0] row_mem [MAX_LEN+1];

  logic [CW-1:0] src_cnt_q, tgt_cnt_q, m_q, n_q, i_q, j_q;
  logic [CW-1:0] left_q, diag_q, dist_q;
  logic          ovf_q, ovf_l_q;
  logic [8:0]    thr_q;
  logic [7:0]    src_rd_q, tgt_rd_q;
  logic [CW-1:0] row_rd_q;
  logic          out_valid_q, within_q, too_long_q;

  logic [CW-1:0] row_raddr, dist_fin;
  logic [AW-1:0] src_raddr;
  logic          cost;
  logic [CW:0]   c_del, c_ins, c_sub, c_best, c_cur;
  logic [CW-1:0] cur;

  // Append counters and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cnt_q <= '0;
      tgt_cnt_q <= '0;
      ovf_q     <= 1'b0;
    end else if (start_i) begin
      src_cnt_q <= '0;
      tgt_cnt_q <= '0;
      ovf_q     <= 1'b0;
    end else if (app_src_i) begin
      if (src_cnt_q < LenMax) src_cnt_q <= src_cnt_q + 1'b1;
      else ovf_q <= 1'b1;
    end else if (app_tgt_i) begin
      if (tgt_cnt_q < LenMax) tgt_cnt_q <= tgt_cnt_q + 1'b1;
      else ovf_q <= 1'b1;
    end
  end

  // String stores, read every cycle
  always_ff @(posedge clk_i) begin
    if (app_src_i && src_cnt_q < LenMax) src_mem[src_cnt_q[AW-1:0]] <= symbol_i;
    if (app_tgt_i && tgt_cnt_q < LenMax) tgt_mem[tgt_cnt_q[AW-1:0]] <= symbol_i;
    src_rd_q <= src_mem[src_raddr];
    tgt_rd_q <= tgt_mem[AW'(j_q - 1'b1)];
  end

  // Read addresses for the next cell
  always_comb begin
    if (cmd_i.pre) begin
      row_raddr = CW'(1);
      src_raddr = '0;
    end else begin
      row_raddr = i_q + 1'b1;
      src_raddr = AW'(i_q);
    end
  end

  // Cell update: min of delete, insert and substitute
  always_comb begin
    cost   = fold_byte(src_rd_q) != fold_byte(tgt_rd_q);
    c_del  = {1'b0, row_rd_q} + 1'b1;
    c_ins  = {1'b0, left_q} + 1'b1;
    c_sub  = {1'b0, diag_q} + {{CW{1'b0}}, cost};
    c_best = (c_del < c_ins) ? c_del : c_ins;
    c_cur  = (c_best < c_sub) ? c_best : c_sub;
    cur    = c_cur[CW-1:0];
  end

  // Row memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) row_mem[i_q] <= i_q;
    else if (cmd_i.calc) row_mem[i_q] <= cur;
    row_rd_q <= row_mem[row_raddr];
  end

  // Compare bookkeeping and loop indexes
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q     <= src_cnt_q;
      n_q     <= tgt_cnt_q;
      thr_q   <= threshold_i;
      ovf_l_q <= ovf_q;
      i_q     <= CW'(1);
      j_q     <= CW'(1);
    end else if (cmd_i.init_wr) begin
      i_q <= i_q + 1'b1;
    end else if (cmd_i.pre) begin
      i_q    <= CW'(1);
      left_q <= j_q;
      diag_q <= j_q - 1'b1;
    end else if (cmd_i.calc) begin
      i_q    <= i_q + 1'b1;
      left_q <= cur;
      diag_q <= row_rd_q;
      if (i_q == m_q) begin
        dist_q <= cur;
        j_q    <= j_q + 1'b1;
      end
    end
  end

  assign sts_o.quick     = ovf_l_q || (thr_q == '0) || (m_q == '0) || (n_q == '0);
  assign sts_o.init_last = (i_q == m_q);
  assign sts_o.cell_last = (i_q == m_q);
  assign sts_o.row_last  = (j_q == n_q);

  assign dist_fin = (m_q == '0) ? n_q : ((n_q == '0) ? m_q : dist_q);

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      within_q   <= !ovf_l_q && (thr_q != '0) && (DW'(dist_fin) < DW'(thr_q));
      too_long_q <= ovf_l_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign within_res_o = within_q;
  assign too_long_o   = too_long_q;
endmodule

// ----- hw/rtl/bounded_edit_distance_check.sv -----
// Bounded edit distance check. Appends are accepted back to back while idle.
// A compare with source length m and target length n gives its result
// after row init, then a load step and m cells per row, and takes no new
// request until it is back in idle; when either string is empty, overflowed
// or the threshold is 0, row init and the rows are skipped.
// Reset (async, active low) clears lengths, overflow flag, state and result valid.
`timescale 1ns / 1ps
`include "bounded_edit_distance_check_defines.svh"
module bounded_edit_distance_check #(
  parameter int unsigned MAX_LEN = bedc_pkg::MaxLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bedc_in_if.sink     req_i,
  bedc_out_if.source  rsp_o
);
  import bedc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic acc, start, out_valid;

  // Take appends whenever idle; hold a compare while a result waits
  assign req_i.ready = cmd.idle && ((req_i.mode != MODE_CMP) || !out_valid);
  assign acc   = req_i.valid && req_i.ready;
  assign start = acc && (req_i.mode == MODE_CMP);

  bedc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  bedc_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .app_src_i    (acc && (req_i.mode == MODE_SRC)),
    .app_tgt_i    (acc && (req_i.mode == MODE_TGT)),
    .start_i      (start),
    .symbol_i     (req_i.symbol),
    .threshold_i  (req_i.threshold),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid),
    .out_ready_i  (rsp_o.ready),
    .within_res_o (rsp_o.within_res),
    .too_long_o   (rsp_o.too_long)
  );

  assign rsp_o.valid = out_valid;

  `BEDC_ASSERT_NEXT(a_cmp_busy, clk_i, rst_ni, start, !cmd.idle)
  `BEDC_ASSERT_NOW(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd))
  `BEDC_ASSERT_NOW(a_rise_after_finish, clk_i, rst_ni, $rose(out_valid), $past(cmd.finish))
  `BEDC_ASSERT_NOW(a_no_cmp_when_full, clk_i, rst_ni, out_valid, !start)
endmodule

// ----- tb/sv/bounded_edit_distance_check_checker.sv -----
// Checker for the bounded edit distance check: watches the request and result channels.
// It predicts each compare answer and counts mismatches. Depends on bedc_pkg and the
// channel interfaces bedc_in_if and bedc_out_if.
`timescale 1ns / 1ps
module bounded_edit_distance_check_checker #(
  parameter int unsigned MAX_LEN = bedc_pkg::MaxLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bedc_in_if          req_i,
  bedc_out_if         rsp_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import bedc_pkg::*;

  typedef struct {
    logic within_res;
    logic too_long;
  } verdict_t;

  logic [7:0]  src_bytes [MAX_LEN];
  logic [7:0]  tgt_bytes [MAX_LEN];
  int unsigned src_len;
  int unsigned tgt_len;
  logic        overflowed;
  verdict_t    verdicts_due[$];

  assign pending_o = verdicts_due.size();

  // Map ASCII upper case onto lower case
  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b | 8'h20;
    end
    return r;
  endfunction

  // Full-table distance over the folded strings
  function automatic int unsigned folded_distance();
    int unsigned prev [MAX_LEN + 1];
    int unsigned cur [MAX_LEN + 1];
    int unsigned best;
    int unsigned diag;
    if (src_len == 0) return tgt_len;
    if (tgt_len == 0) return src_len;
    for (int i = 0; i <= src_len; i++) prev[i] = i;
    for (int j = 1; j <= tgt_len; j++) begin
      cur[0] = j;
      for (int i = 1; i <= src_len; i++) begin
        diag = prev[i-1] +
               ((lower_ascii(src_bytes[i-1]) != lower_ascii(tgt_bytes[j-1])) ? 1 : 0);
        best = (prev[i] + 1 < cur[i-1] + 1) ? prev[i] + 1 : cur[i-1] + 1;
        cur[i] = (best < diag) ? best : diag;
      end
      prev = cur;
    end
    return prev[src_len];
  endfunction

  task automatic report_mismatch(input string what, input logic expv, input logic gotv);
    $display("[%0t] mismatch on %s: expected %0b, got %0b", $realtime, what, expv, gotv);
    fail_count_o++;
  endtask

  // Track requests, predict compares, check results
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    if (!rst_ni) begin
      src_len = 0;
      tgt_len = 0;
      overflowed = 1'b0;
      fail_count_o = 0;
      verdicts_due.delete();
    end else begin
      if (rsp_o.valid && rsp_o.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected result valid", 1'b0, 1'b1);
        end else begin
          v = verdicts_due.pop_front();
          if (rsp_o.within_res !== v.within_res)
            report_mismatch("within_res", v.within_res, rsp_o.within_res);
          if (rsp_o.too_long !== v.too_long)
            report_mismatch("too_long", v.too_long, rsp_o.too_long);
        end
      end
      if (req_i.valid && req_i.ready) begin
        case (req_i.mode)
          MODE_SRC: begin
            if (src_len < MAX_LEN) begin
              src_bytes[src_len] = req_i.symbol;
              src_len++;
            end else begin
              overflowed = 1'b1;
            end
          end
          MODE_TGT: begin
            if (tgt_len < MAX_LEN) begin
              tgt_bytes[tgt_len] = req_i.symbol;
              tgt_len++;
            end else begin
              overflowed = 1'b1;
            end
          end
          MODE_CMP: begin
            v.too_long = overflowed;
            v.within_res = !overflowed && req_i.threshold != 0 &&
                           folded_distance() < req_i.threshold;
            verdicts_due.push_back(v);
            src_len = 0;
            tgt_len = 0;
            overflowed = 1'b0;
          end
          default: begin
            // drop unused mode
          end
        endcase
      end
    end
  end
endmodule

// ----- tb/sv/bounded_edit_distance_check_tb.sv -----
// Testbench top for the bounded edit distance check: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on bedc_pkg, the channel interfaces,
// the block and bounded_edit_distance_check_checker.
`timescale 1ns / 1ps
module bounded_edit_distance_check_tb;
  import bedc_pkg::*;

  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 100000;
  localparam int unsigned ITEM_GOAL = 850;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned stall_pct;
  int unsigned phase_ctr;

  bedc_in_if  req_if ();
  bedc_out_if rsp_if ();

  bounded_edit_distance_check dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bounded_edit_distance_check_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_o        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Stall the result side, redrawing how hard on a phase counter
  always @(negedge clk_i) begin
    phase_ctr <= phase_ctr + 1;
    if (phase_ctr % 128 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Send one request in bursts with random gaps
  task automatic send_request(input logic [1:0] m, input logic [7:0] s, input logic [8:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.mode      <= m;
    req_if.symbol    <= s;
    req_if.threshold <= t;
    do @(posedge clk_i); while (!req_if.ready);
    if (m != MODE_UNUSED) items_sent++;
  endtask

  // Hold off until every expected result is back
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_text(input logic [1:0] m, input string txt);
    for (int i = 0; i < txt.len(); i++)
      send_request(m, txt[i], 9'($urandom_range(0, 511)));
  endtask

  function automatic logic [7:0] pick_symbol();
    logic [7:0] r;
    case ($urandom_range(0, 4))
      0, 1: r = 8'h41 + 8'($urandom_range(0, 1)) + (($urandom_range(0, 1) != 0) ? 8'h20 : 8'h00);
      2: r = 8'($urandom_range(8'h40, 8'h5B));
      3: r = 8'($urandom_range(8'h60, 8'h7B));
      default: r = 8'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  // One source/target pair followed by a compare, target mostly a mutated source
  task automatic send_pair();
    logic [7:0]  src_q[$];
    logic [7:0]  tgt_q[$];
    int unsigned edits;
    int unsigned pos;
    int unsigned sel;
    logic [8:0]  thr;
    sel = $urandom_range(0, 39);
    if (sel == 0) begin
      // one side near or past full length
      repeat ($urandom_range(250, 259)) src_q.push_back(pick_symbol());
      repeat ($urandom_range(0, 3)) tgt_q.push_back(pick_symbol());
      if ($urandom_range(0, 1)) begin
        tgt_q = src_q;
        src_q.delete();
        repeat ($urandom_range(0, 3)) src_q.push_back(pick_symbol());
      end
    end else begin
      repeat ($urandom_range(0, 12)) src_q.push_back(pick_symbol());
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(0, 12)) tgt_q.push_back(pick_symbol());
      end else begin
        tgt_q = src_q;
        edits = $urandom_range(0, 4);
        repeat (edits) begin
          pos = $urandom_range(0, tgt_q.size());
          case ($urandom_range(0, 2))
            0: tgt_q.insert(pos, pick_symbol());
            1: if (pos < tgt_q.size()) tgt_q.delete(pos);
            default: if (pos < tgt_q.size()) tgt_q[pos] = pick_symbol();
          endcase
        end
      end
    end
    // interleave the two strings at random
    while (src_q.size() + tgt_q.size() > 0) begin
      if ($urandom_range(0, 49) == 0) send_request(MODE_UNUSED, 8'($urandom), 9'($urandom));
      if (tgt_q.size() == 0 || (src_q.size() > 0 && $urandom_range(0, 1)))
        send_request(MODE_SRC, src_q.pop_front(), 9'($urandom_range(0, 511)));
      else
        send_request(MODE_TGT, tgt_q.pop_front(), 9'($urandom_range(0, 511)));
    end
    thr = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 8));
    send_request(MODE_CMP, 8'($urandom_range(0, 255)), thr);
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.mode      = MODE_SRC;
    req_if.symbol    = '0;
    req_if.threshold = '0;
    rsp_if.ready     = 1'b0;
    idle_cycles      = 0;
    burst_left       = 0;
    items_sent       = 0;
    stall_pct        = 0;
    phase_ctr        = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty strings, zero and top thresholds, case folding, edges
    send_request(MODE_CMP, 8'h00, 9'd1);
    send_request(MODE_CMP, 8'hFF, 9'd0);
    send_request(MODE_UNUSED, 8'hFF, 9'h1FF);
    send_text(MODE_SRC, "AZ@[");
    send_text(MODE_TGT, "az@[");
    send_request(MODE_CMP, 8'h00, 9'd1);
    send_text(MODE_TGT, "`{");
    send_text(MODE_SRC, "@[");
    send_request(MODE_CMP, 8'h00, 9'h1FF);
    send_text(MODE_SRC, "kitten");
    send_request(MODE_SRC, 8'hFF, 9'd0);
    send_request(MODE_TGT, 8'h00, 9'd0);
    send_request(MODE_CMP, 8'h00, 9'd7);
    send_text(MODE_TGT, "abc");
    send_request(MODE_CMP, 8'h00, 9'd3);
    drain_results();

    // Random pairs until the item goal
    while (items_sent < ITEM_GOAL) begin
      send_pair();
      if ($urandom_range(0, 29) == 0) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/bedc_pkg.sv
hw/rtl/bedc_in_if.sv
hw/rtl/bedc_out_if.sv
hw/rtl/bedc_ctrl.sv
hw/rtl/bedc_dp.sv
hw/rtl/bounded_edit_distance_check.sv
tb/sv/bounded_edit_distance_check_checker.sv
tb/sv/bounded_edit_distance_check_tb.sv
